[rtl/sem_pkg.sv]
// ----------------------------------------------------------------------------
// sem_pkg - shared definitions for the Sobel edge magnitude block
// Field widths, register indexes, reset values and the sequencer state type.
// ----------------------------------------------------------------------------
package sem_pkg;

    localparam int CH_BITS        = 8;
    localparam int NUM_CH         = 3;
    localparam int PIX_W          = NUM_CH * CH_BITS;
    localparam int RAD_W          = 2 * CH_BITS;
    localparam int CFG_W          = 12;
    localparam int ROW_W          = 12;
    localparam int OUT_COL_W      = 11;
    localparam int S_TDATA_W      = 24;
    localparam int M_TDATA_W      = 48;
    localparam int REG_IDX_W      = 1;
    localparam int DEF_MAX_WIDTH  = 2048;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 12'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 12'd480;

    // sums of squares at or above this give a magnitude of 255
    localparam logic [2*CH_BITS+4:0] MAG_CLAMP = 21'd65280;
    localparam logic [CH_BITS-1:0]   MAG_MAX   = 8'd255;

    localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    typedef logic [PIX_W-1:0] pix_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_GRAD,
        ST_SQR,
        ST_SUM,
        ST_ROOT,
        ST_OUT
    } state_t;

endpackage

[rtl/sem_sqrt.sv]
// ----------------------------------------------------------------------------
// sem_sqrt - iterative rounded integer square root
// Two radicand bits per cycle; result rounded half up.
// ----------------------------------------------------------------------------
module sem_sqrt import sem_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [RAD_W-1:0]   radicand,
    output logic               done,
    output logic [CH_BITS-1:0] root
);

    localparam int CNT_W = $clog2(CH_BITS);

    logic [RAD_W-1:0]   rad_reg,  rad_next;
    logic [CH_BITS:0]   rem_reg,  rem_next;
    logic [CH_BITS-1:0] root_reg, root_next;
    logic [CNT_W-1:0]   cnt_reg,  cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;

    logic [CH_BITS+2:0] rem_sh;
    logic [CH_BITS+2:0] trial;
    logic               ge;

    always_comb begin
        rem_sh    = {rem_reg, rad_reg[RAD_W-1 -: 2]};
        trial     = (CH_BITS+3)'({root_reg, 2'b01});
        ge        = rem_sh >= trial;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rad_next  = rad_reg << 2;
            rem_next  = (CH_BITS+1)'(ge ? rem_sh - trial : rem_sh);
            root_next = {root_reg[CH_BITS-2:0], ge};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(CH_BITS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    // round half up: remainder above root means s is past root + 1/2 squared
    assign root = root_reg + CH_BITS'(rem_reg > {1'b0, root_reg});
    assign done = done_reg;

endmodule

[rtl/sobel_edge_magnitude_rgb.sv]
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_rgb - 3x3 Sobel gradient magnitude on RGB pixels
// Raster-order pixel stream in, per-channel edge magnitude stream out.
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one beat per pixel, for a frame of
// frame_width x frame_height; each channel gets its own Sobel Gx/Gy and the
// result is round(sqrt(gx^2+gy^2)) clamped to 255, with pixels outside the
// frame taken as zero. Output lags one row and one column: a pixel beat
// releases zero to four result beats (more at the row end and on the last
// row), m_tlast marks the last result released by that pixel and m_tuser
// marks the final pixel of the frame. Per pixel: ST_LOAD (line memory
// read-modify-write), then per result ST_GRAD, ST_SQR, ST_SUM, ST_ROOT
// (waiting on the 8-step square-root units, one per channel, run together)
// and ST_OUT; only ST_IDLE takes a new pixel. The two previous rows live in
// one line memory of MAX_WIDTH entries, needing no clearing after reset.
// The user must write frame_width and frame_height through cfg_* while the
// block is idle (unenforced); 0 is taken as 1, above MAX_WIDTH as MAX_WIDTH.
module sobel_edge_magnitude_rgb import sem_pkg::*; #(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration write port
    input  logic                 cfg_wr_en,
    input  logic [REG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata,
    // pixel input
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // in_red[7:0], in_green[15:8], in_blue[23:16]
    // magnitude output
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // out_red[7:0], out_green[15:8],
                                            // out_blue[23:16], out_row[35:24],
                                            // out_col[46:36], zero[47]
    output logic                 m_tlast,   // run_last
    output logic                 m_tuser    // frame_done
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int DIM_W = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
    localparam int SUM_W = CH_BITS + 2;          // 1*a + 2*b + 1*c
    localparam int SQ_W  = 2 * SUM_W;
    localparam int SS_W  = SQ_W + 1;

    // ---- configuration --------------------------------------------------
    logic [CFG_W-1:0] frame_width_reg;
    logic [CFG_W-1:0] frame_height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // effective last column / last row
    logic [DIM_W-1:0] width_ext;
    logic [DIM_W-1:0] w_m1;
    logic [ROW_W-1:0] h_m1;

    always_comb begin
        width_ext = DIM_W'(frame_width_reg);
        if (width_ext == '0)
            w_m1 = '0;
        else if (width_ext > DIM_W'(MAX_WIDTH))
            w_m1 = DIM_W'(MAX_WIDTH - 1);
        else
            w_m1 = width_ext - 1'b1;
        h_m1 = (frame_height_reg == '0) ? '0 : ROW_W'(frame_height_reg - 1'b1);
    end

    // ---- state ------------------------------------------------------------
    state_t state_reg, state_next;

    logic [ROW_W-1:0] cur_row_reg;
    logic [COL_W-1:0] cur_col_reg;

    // latched pixel beat and its position
    pix_t             pix_reg;
    logic [ROW_W-1:0] pix_row_reg;
    logic [COL_W-1:0] pix_col_reg;
    logic             row_end_reg;
    logic             last_row_reg;

    // line memory: {row r-2, row r-1} per column
    logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] rd_reg;

    pix_t win_reg [3][3];                        // [row r-2..r][col c-2..c]

    logic [3:0] pend_reg;                        // results still owed for this pixel
    logic [1:0] sel_reg;                         // {row offset, col offset}

    logic [SUM_W-1:0] agx_reg [NUM_CH];
    logic [SUM_W-1:0] agy_reg [NUM_CH];
    logic [SQ_W-1:0]  sqx_reg [NUM_CH];
    logic [SQ_W-1:0]  sqy_reg [NUM_CH];
    logic             clamp_reg [NUM_CH];

    logic               m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic               m_tlast_reg;
    logic               m_tuser_reg;

    // ---- handshake and position decode -----------------------------------
    logic s_accept;
    logic row_end;
    logic last_row;
    logic out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign row_end  = DIM_W'(cur_col_reg) >= w_m1;
    assign last_row = cur_row_reg >= h_m1;
    assign out_free = !m_tvalid_reg || m_tready;

    // results released by the pixel, in emission order
    logic [3:0] pend_new;
    always_comb begin
        pend_new[0] = (pix_row_reg != '0) && (pix_col_reg != '0);
        pend_new[1] = (pix_row_reg != '0) && row_end_reg;
        pend_new[2] = last_row_reg && (pix_col_reg != '0);
        pend_new[3] = last_row_reg && row_end_reg;
    end

    function automatic logic [1:0] first_set(input logic [3:0] v);
        logic [1:0] idx;
        idx = 2'd3;
        for (int k = 3; k >= 0; k--)
            if (v[k])
                idx = 2'(k);
        return idx;
    endfunction

    logic [3:0] pend_rest;
    logic       rest_none;
    assign pend_rest = pend_reg & ~(4'b0001 << sel_reg);
    assign rest_none = (pend_rest == 4'b0000);

    // ---- 3x3 selection and gradients -------------------------------------
    logic [CH_BITS-1:0] grid [NUM_CH][4][4];     // masked, row 3 / col 3 outside
    logic [CH_BITS-1:0] sw   [NUM_CH][3][3];
    logic [2:0]         rv;
    logic [2:0]         cv;
    logic [SUM_W-1:0]   px, nx, py, ny;
    logic [SUM_W-1:0]   agx [NUM_CH];
    logic [SUM_W-1:0]   agy [NUM_CH];

    assign rv = {1'b1, pix_row_reg != '0, pix_row_reg > ROW_W'(1)};
    assign cv = {1'b1, pix_col_reg != '0, pix_col_reg > COL_W'(1)};

    always_comb begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            for (int i = 0; i < 4; i++)
                for (int j = 0; j < 4; j++)
                    grid[ch][i][j] = '0;
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    grid[ch][i][j] = (rv[i] && cv[j]) ?
                                     win_reg[i][j][ch*CH_BITS +: CH_BITS] : '0;
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    sw[ch][i][j] = grid[ch][2'(i) + {1'b0, sel_reg[1]}]
                                           [2'(j) + {1'b0, sel_reg[0]}];
        end
    end

    always_comb begin
        px = '0; nx = '0; py = '0; ny = '0;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            px = SUM_W'(sw[ch][0][2]) + (SUM_W'(sw[ch][1][2]) << 1) + SUM_W'(sw[ch][2][2]);
            nx = SUM_W'(sw[ch][0][0]) + (SUM_W'(sw[ch][1][0]) << 1) + SUM_W'(sw[ch][2][0]);
            py = SUM_W'(sw[ch][2][0]) + (SUM_W'(sw[ch][2][1]) << 1) + SUM_W'(sw[ch][2][2]);
            ny = SUM_W'(sw[ch][0][0]) + (SUM_W'(sw[ch][0][1]) << 1) + SUM_W'(sw[ch][0][2]);
            agx[ch] = (px >= nx) ? px - nx : nx - px;
            agy[ch] = (py >= ny) ? py - ny : ny - py;
        end
    end

    // ---- square root units ------------------------------------------------
    logic               sq_start;
    logic [SS_W-1:0]    ssum  [NUM_CH];
    logic [NUM_CH-1:0]  sq_done;
    logic [CH_BITS-1:0] sq_root [NUM_CH];
    logic [CH_BITS-1:0] mag   [NUM_CH];

    assign sq_start = (state_reg == ST_SUM);

    genvar g;
    generate
        for (g = 0; g < NUM_CH; g++) begin : g_ch
            assign ssum[g] = SS_W'(sqx_reg[g]) + SS_W'(sqy_reg[g]);
            assign mag[g]  = clamp_reg[g] ? MAG_MAX : sq_root[g];

            sem_sqrt u_sqrt (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .start    (sq_start),
                .radicand (ssum[g][RAD_W-1:0]),
                .done     (sq_done[g]),
                .root     (sq_root[g])
            );
        end
    endgenerate

    // output position of the selected result
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col_full;
    assign out_row      = pix_row_reg + ROW_W'(sel_reg[1]) - ROW_W'(1);
    assign out_col_full = pix_col_reg + COL_W'(sel_reg[0]) - COL_W'(1);

    // ---- sequencer --------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_accept) state_next = ST_LOAD;
            ST_LOAD: state_next = (pend_new == 4'b0000) ? ST_IDLE : ST_GRAD;
            ST_GRAD: state_next = ST_SQR;
            ST_SQR:  state_next = ST_SUM;
            ST_SUM:  state_next = ST_ROOT;
            ST_ROOT: if (&sq_done) state_next = ST_OUT;
            ST_OUT: begin
                if (out_free)
                    state_next = rest_none ? ST_IDLE : ST_GRAD;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // ---- line memory: read on accept, write back in ST_LOAD --------------
    always_ff @(posedge aclk) begin
        rd_reg <= line_mem[cur_col_reg];
        if (state_reg == ST_LOAD)
            line_mem[pix_col_reg] <= {rd_reg[PIX_W-1:0], pix_reg};
    end

    // ---- position and control ---------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_row_reg  <= '0;
            cur_col_reg  <= '0;
            pend_reg     <= '0;
            sel_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // load a new beat, or drop the one taken by the receiver
            if (state_reg == ST_OUT && out_free)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        if (row_end) begin
                            cur_col_reg <= '0;
                            cur_row_reg <= last_row ? '0 : cur_row_reg + 1'b1;
                        end else begin
                            cur_col_reg <= cur_col_reg + 1'b1;
                        end
                    end
                end
                ST_LOAD: begin
                    pend_reg <= pend_new;
                    sel_reg  <= first_set(pend_new);
                end
                ST_OUT: begin
                    if (out_free) begin
                        pend_reg     <= pend_rest;
                        sel_reg      <= first_set(pend_rest);
                    end
                end
                default: ;
            endcase
        end
    end

    // ---- payload ----------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            pix_reg      <= s_tdata;
            pix_row_reg  <= cur_row_reg;
            pix_col_reg  <= cur_col_reg;
            row_end_reg  <= row_end;
            last_row_reg <= last_row;
        end
        if (state_reg == ST_LOAD) begin
            for (int k = 0; k < 3; k++) begin
                win_reg[k][0] <= win_reg[k][1];
                win_reg[k][1] <= win_reg[k][2];
            end
            win_reg[0][2] <= rd_reg[2*PIX_W-1:PIX_W];
            win_reg[1][2] <= rd_reg[PIX_W-1:0];
            win_reg[2][2] <= pix_reg;
        end
        for (int ch = 0; ch < NUM_CH; ch++) begin
            if (state_reg == ST_GRAD) begin
                agx_reg[ch] <= agx[ch];
                agy_reg[ch] <= agy[ch];
            end
            if (state_reg == ST_SQR) begin
                sqx_reg[ch] <= agx_reg[ch] * agx_reg[ch];
                sqy_reg[ch] <= agy_reg[ch] * agy_reg[ch];
            end
            if (state_reg == ST_SUM)
                clamp_reg[ch] <= ssum[ch] >= MAG_CLAMP;
        end
        if (state_reg == ST_OUT && out_free) begin
            m_tdata_reg <= {1'b0, OUT_COL_W'(out_col_full), out_row,
                            mag[2], mag[1], mag[0]};
            m_tlast_reg <= rest_none;
            m_tuser_reg <= (sel_reg == 2'd3);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    // ---- assertions -------------------------------------------------------
    // end of frame is always the last beat released by its pixel
    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("frame_done beat without run_last");

    // a result is only computed when one is owed
    a_grad_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_GRAD) |-> (pend_reg != 4'b0000))
        else $error("gradient pass with no pending result");

    // root units finish only while the sequencer waits for them
    a_root_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (|sq_done) |-> (state_reg == ST_ROOT))
        else $error("square root finished outside wait state");

    // a blocked output slot holds the sequencer in place
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && m_tvalid && !m_tready) |=> (state_reg == ST_OUT))
        else $error("result dropped while output stalled");

endmodule
